[hw/rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define LOS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define LOS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/los_pkg.sv]
package los_pkg;

  localparam int CORNER_DEPTH = 256;
  localparam int COORD_BITS = 24;
  localparam int THR_BITS = 16;
  localparam int ADDR_BITS = $clog2(CORNER_DEPTH);
  localparam int CNT_BITS = ADDR_BITS + 1;
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int MUL_BITS = (DIFF_BITS + 1 > THR_BITS + 1) ? DIFF_BITS + 1 : THR_BITS + 1;
  localparam int PROD_BITS = 2 * MUL_BITS;
  localparam int ACC_BITS = PROD_BITS + 1;
  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(32);

  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_APPEND  = 2'd1,
    REQ_QUERY   = 2'd2,
    REQ_VEHICLE = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    COND_LOS   = 2'd0,
    COND_NLOS  = 2'd1,
    COND_NLOSV = 2'd2,
    COND_RSVD  = 2'd3
  } cond_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_LATCH,
    S_MUL,
    S_DEC,
    S_FIN,
    S_VMUL,
    S_VDEC,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]                   req_type;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] far_x;
    logic signed [COORD_BITS-1:0] far_y;
    logic                         building_end;
    logic                         no_vehicles;
    logic                         last_vehicle;
  } req_t;

  typedef struct packed {
    logic [1:0] condition;
    logic       table_overflow;
  } rsp_t;

  typedef struct packed {
    logic                         end_flag;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } corner_t;

endpackage

[hw/rtl/los_ram.sv]
module los_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/line_of_sight_classifier_unit.sv]
// Line-of-sight classifier.
// Request channel (req_valid/req_stall/req) takes clear, append, query and
// vehicle requests; a request is taken when req_valid is high and req_stall low.
// Response channel (rsp_valid/rsp_stall/rsp) carries condition and the sticky
// table_overflow flag. Config channel (cfg_valid/cfg_ready/cfg_data) writes
// the vehicle threshold; cfg_ready is always high.
// Clear and append leave req_stall low. A query reads the corner table
// through one RAM port and runs each non-skipped edge through one shared 26x26
// multiplier. From the accept on it holds req_stall: S_RD and S_LATCH load the
// first corner and each corner after a building's last corner; each tested
// edge passes S_RD, S_LATCH, the S_MUL steps and S_DEC; S_FIN finishes the
// query, followed by S_EMIT when no_vehicles is set.
// A vehicle request holds req_stall through S_VMUL and S_VDEC on the same
// multiplier, followed by S_EMIT when last_vehicle is set.
// A finished response waits in the output register while rsp_stall is high;
// the next request is accepted meanwhile and holds only at its own response.
// rst (synchronous) empties the table, clears flags and endpoints and sets
// the threshold to 32.
module line_of_sight_classifier_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  los_pkg::req_t            req,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output los_pkg::rsp_t            rsp,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [los_pkg::THR_BITS-1:0] cfg_data
);
  import los_pkg::*;

  state_t state, state_next;

  logic [THR_BITS-1:0]          thr;
  logic [CNT_BITS-1:0]          count;
  logic [CNT_BITS-1:0]          idx;
  logic                         ovf;
  logic                         bhit;
  logic                         vhit;
  logic                         nov;
  logic                         vlast;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic signed [DIFF_BITS-1:0]  dx;
  logic signed [DIFF_BITS-1:0]  dy;
  logic signed [DIFF_BITS-1:0]  sx;
  logic signed [DIFF_BITS-1:0]  sy;
  logic signed [DIFF_BITS-1:0]  wx;
  logic signed [DIFF_BITS-1:0]  wy;
  corner_t                      prev;
  corner_t                      cur;
  corner_t                      rdata;
  logic [2:0]                   step;
  logic signed [MUL_BITS-1:0]   mul_a;
  logic signed [MUL_BITS-1:0]   mul_b;
  logic signed [PROD_BITS-1:0]  prod;
  logic signed [ACC_BITS-1:0]   acc_d;
  logic signed [ACC_BITS-1:0]   acc_t;
  logic signed [ACC_BITS-1:0]   acc_u;
  logic signed [ACC_BITS-1:0]   acc_e;
  logic signed [MUL_BITS-1:0]   abs_dx;
  logic                         accept;
  logic                         more;
  logic                         ram_we;
  logic                         edge_hit;
  logic                         blocks;
  logic                         out_free;
  corner_t                      wcorner;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign more      = (CNT_BITS'(idx + 1'b1) < count);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign ram_we    = accept && (req.req_type == REQ_APPEND) && (count < CNT_BITS'(CORNER_DEPTH));

  assign wcorner.end_flag = req.building_end;
  assign wcorner.x        = req.point_x;
  assign wcorner.y        = req.point_y;

  los_ram #(
    .WIDTH($bits(corner_t)),
    .DEPTH(CORNER_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[ADDR_BITS-1:0]),
    .wdata(wcorner),
    .raddr(idx[ADDR_BITS-1:0]),
    .rdata(rdata)
  );

  assign abs_dx = dx[DIFF_BITS-1] ? -MUL_BITS'(dx) : MUL_BITS'(dx);

  always_comb begin
    mul_a = MUL_BITS'(dx);
    mul_b = MUL_BITS'(sy);
    if (state == S_VMUL) begin
      case (step)
        3'd0: begin
          mul_a = MUL_BITS'(dy);
          mul_b = MUL_BITS'(wx);
        end
        3'd1: begin
          mul_a = MUL_BITS'(dx);
          mul_b = MUL_BITS'(wy);
        end
        default: begin
          mul_a = MUL_BITS'($signed({1'b0, thr}));
          mul_b = abs_dx;
        end
      endcase
    end else begin
      case (step)
        3'd0: begin
          mul_a = MUL_BITS'(dx);
          mul_b = MUL_BITS'(sy);
        end
        3'd1: begin
          mul_a = MUL_BITS'(dy);
          mul_b = MUL_BITS'(sx);
        end
        3'd2: begin
          mul_a = MUL_BITS'(wx);
          mul_b = MUL_BITS'(sy);
        end
        3'd3: begin
          mul_a = MUL_BITS'(wy);
          mul_b = MUL_BITS'(sx);
        end
        3'd4: begin
          mul_a = MUL_BITS'(wx);
          mul_b = MUL_BITS'(dy);
        end
        default: begin
          mul_a = MUL_BITS'(wy);
          mul_b = MUL_BITS'(dx);
        end
      endcase
    end
  end

  always_comb begin
    if (acc_d < 0) begin
      edge_hit = (acc_t <= 0) && (acc_t >= acc_d) && (acc_u <= 0) && (acc_u >= acc_d);
    end else begin
      edge_hit = (acc_d != 0) && (acc_t >= 0) && (acc_t <= acc_d) &&
                 (acc_u >= 0) && (acc_u <= acc_d);
    end
    acc_e  = (acc_d < 0) ? -acc_d : acc_d;
    blocks = (dx != 0) && (acc_e < acc_t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && req.req_type == REQ_QUERY) begin
          state_next = (count < CNT_BITS'(2)) ? S_FIN : S_RD;
        end else if (accept && req.req_type == REQ_VEHICLE) begin
          state_next = S_VMUL;
        end
      end
      S_RD:    state_next = S_LATCH;
      S_LATCH: begin
        if (idx == '0) begin
          state_next = S_RD;
        end else if (prev.end_flag) begin
          state_next = more ? S_RD : S_FIN;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL:   state_next = (step == 3'd6) ? S_DEC : S_MUL;
      S_DEC:   state_next = (edge_hit || !more) ? S_FIN : S_RD;
      S_FIN:   state_next = nov ? S_EMIT : S_IDLE;
      S_VMUL:  state_next = (step == 3'd3) ? S_VDEC : S_VMUL;
      S_VDEC:  state_next = vlast ? S_EMIT : S_IDLE;
      S_EMIT:  state_next = out_free ? S_IDLE : S_EMIT;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        if (accept && req.req_type == REQ_VEHICLE) begin
          wx    <= DIFF_BITS'(req.point_x) - DIFF_BITS'(px);
          wy    <= DIFF_BITS'(req.point_y) - DIFF_BITS'(py);
          vlast <= req.last_vehicle;
          step  <= '0;
        end
      end
      S_LATCH: begin
        if (idx == '0 || prev.end_flag) begin
          prev <= rdata;
        end else begin
          cur  <= rdata;
          sx   <= DIFF_BITS'(rdata.x) - DIFF_BITS'(prev.x);
          sy   <= DIFF_BITS'(rdata.y) - DIFF_BITS'(prev.y);
          wx   <= DIFF_BITS'(prev.x) - DIFF_BITS'(px);
          wy   <= DIFF_BITS'(prev.y) - DIFF_BITS'(py);
          step <= '0;
        end
      end
      S_MUL, S_VMUL: begin
        step <= step + 3'd1;
        case (step)
          3'd1:    acc_d <= ACC_BITS'(prod);
          3'd2:    acc_d <= acc_d - ACC_BITS'(prod);
          3'd3:    acc_t <= ACC_BITS'(prod);
          3'd4:    acc_t <= acc_t - ACC_BITS'(prod);
          3'd5:    acc_u <= ACC_BITS'(prod);
          3'd6:    acc_u <= acc_u - ACC_BITS'(prod);
          default: acc_u <= acc_u;
        endcase
      end
      S_DEC: begin
        prev <= cur;
      end
      default: begin
        prev <= prev;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr       <= THR_RESET;
      count     <= '0;
      idx       <= '0;
      ovf       <= 1'b0;
      bhit      <= 1'b0;
      vhit      <= 1'b0;
      nov       <= 1'b0;
      px        <= '0;
      py        <= '0;
      dx        <= '0;
      dy        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr <= cfg_data;
      end
      if (state == S_EMIT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req_kind_t'(req.req_type))
              REQ_CLEAR: begin
                count <= '0;
                ovf   <= 1'b0;
              end
              REQ_APPEND: begin
                if (ram_we) begin
                  count <= count + 1'b1;
                end else begin
                  ovf <= 1'b1;
                end
              end
              REQ_QUERY: begin
                px   <= req.point_x;
                py   <= req.point_y;
                dx   <= DIFF_BITS'(req.far_x) - DIFF_BITS'(req.point_x);
                dy   <= DIFF_BITS'(req.far_y) - DIFF_BITS'(req.point_y);
                idx  <= '0;
                bhit <= 1'b0;
                vhit <= 1'b0;
                nov  <= req.no_vehicles;
              end
              default: begin
                nov <= nov;
              end
            endcase
          end
        end
        S_LATCH: begin
          if (idx == '0 || prev.end_flag) begin
            idx <= idx + 1'b1;
          end
        end
        S_DEC: begin
          if (edge_hit) begin
            bhit <= 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_VDEC: begin
          if (!bhit && !vhit && blocks) begin
            vhit <= 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            vhit <= 1'b0;
          end
        end
        default: begin
          idx <= idx;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      rsp.condition      <= bhit ? COND_NLOS : (vhit ? COND_NLOSV : COND_LOS);
      rsp.table_overflow <= ovf;
    end
  end

endmodule

[hw/rtl/los_chk.sv]
`include "assert_macros.svh"

module los_chk (
  input logic                     clk,
  input logic                     rst,
  input logic                     req_valid,
  input logic                     req_stall,
  input los_pkg::req_t            req,
  input logic                     rsp_valid,
  input logic                     rsp_stall,
  input los_pkg::rsp_t            rsp,
  input logic                     cfg_valid,
  input logic                     cfg_ready,
  input logic [los_pkg::THR_BITS-1:0] cfg_data
);
  import los_pkg::*;

  logic take;
  logic unused_cfg;

  assign take       = req_valid && !req_stall;
  assign unused_cfg = cfg_valid ^ (|cfg_data);

  `LOS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "response dropped")
  `LOS_ASSERT_NOW(a_cond_code, rsp_valid, rsp.condition != COND_RSVD, "bad condition code")
  `LOS_ASSERT_NEXT(a_table_fast, take && !req.req_type[1], !req_stall, "table request not done")
  `LOS_ASSERT_NEXT(a_query_busy, take && req.req_type[1], req_stall, "query not held")
  `LOS_ASSERT_NOW(a_cfg_ready, !rst && !unused_cfg, cfg_ready, "config not ready")

endmodule

bind line_of_sight_classifier_unit los_chk u_los_chk (.*);

[tb/sv/tb_top.sv]
module tb_top;
  import los_pkg::*;

  localparam int DRAIN_CYCLES = 2700;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint CMAX = 64'sd8388607;
  localparam longint CMIN = -64'sd8388608;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  logic cfg_valid;
  logic cfg_ready;
  logic [THR_BITS-1:0] cfg_data;

  line_of_sight_classifier_unit i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // classifier image
  longint corner_x [CORNER_DEPTH];
  longint corner_y [CORNER_DEPTH];
  bit corner_last [CORNER_DEPTH];
  int corner_cnt;
  bit overflow_seen;
  longint link_x1, link_y1, link_x2, link_y2;
  bit blocked_by_building;
  bit blocked_by_vehicle;
  longint threshold;

  rsp_t expected_conditions[$];
  int errors = 0;
  int requests_sent;
  int results_seen = 0;
  int burst_left;
  int cycle_cnt = 0;
  int idle_cnt = 0;

  function automatic bit link_crosses_edge(longint ax, longint ay, longint bx, longint by);
    longint rx, ry, sx, sy, wx, wy, d, tn, un;
    rx = link_x2 - link_x1; ry = link_y2 - link_y1;
    sx = bx - ax; sy = by - ay;
    wx = ax - link_x1; wy = ay - link_y1;
    d = rx * sy - ry * sx;
    tn = wx * sy - wy * sx;
    un = wx * ry - wy * rx;
    if (d == 0) return 1'b0;
    if (d < 0) begin
      d = -d; tn = -tn; un = -un;
    end
    return tn >= 0 && tn <= d && un >= 0 && un <= d;
  endfunction

  function automatic bit vehicle_in_link(longint vx, longint vy);
    longint dx, dy, e, lim;
    dx = link_x2 - link_x1;
    dy = link_y2 - link_y1;
    if (dx == 0) return 1'b0;
    e = dy * (vx - link_x1) - dx * (vy - link_y1);
    if (e < 0) e = -e;
    lim = threshold * (dx < 0 ? -dx : dx);
    return e < lim;
  endfunction

  function automatic rsp_t current_condition();
    rsp_t o;
    o.condition = blocked_by_building ? COND_NLOS : (blocked_by_vehicle ? COND_NLOSV : COND_LOS);
    o.table_overflow = overflow_seen;
    return o;
  endfunction

  task automatic classify(input req_t r);
    case (req_kind_t'(r.req_type))
      REQ_CLEAR: begin
        corner_cnt = 0;
        overflow_seen = 1'b0;
      end
      REQ_APPEND: begin
        if (corner_cnt >= CORNER_DEPTH) begin
          overflow_seen = 1'b1;
        end else begin
          corner_x[corner_cnt] = r.point_x;
          corner_y[corner_cnt] = r.point_y;
          corner_last[corner_cnt] = r.building_end;
          corner_cnt++;
        end
      end
      REQ_QUERY: begin
        link_x1 = r.point_x; link_y1 = r.point_y;
        link_x2 = r.far_x; link_y2 = r.far_y;
        blocked_by_building = 1'b0;
        blocked_by_vehicle = 1'b0;
        for (int i = 0; i + 1 < corner_cnt; i++) begin
          if (!corner_last[i] &&
              link_crosses_edge(corner_x[i], corner_y[i], corner_x[i+1], corner_y[i+1])) begin
            blocked_by_building = 1'b1;
            break;
          end
        end
        if (r.no_vehicles) expected_conditions.push_back(current_condition());
      end
      default: begin
        if (!blocked_by_building && !blocked_by_vehicle && vehicle_in_link(r.point_x, r.point_y))
          blocked_by_vehicle = 1'b1;
        if (r.last_vehicle) begin
          expected_conditions.push_back(current_condition());
          blocked_by_vehicle = 1'b0;
        end
      end
    endcase
  endtask

  function automatic req_t mk(req_kind_t k, longint px, longint py, longint fx, longint fy,
                              bit be, bit nv, bit lv);
    req_t r;
    r.req_type = k;
    r.point_x = px[COORD_BITS-1:0];
    r.point_y = py[COORD_BITS-1:0];
    r.far_x = fx[COORD_BITS-1:0];
    r.far_y = fy[COORD_BITS-1:0];
    r.building_end = be;
    r.no_vehicles = nv;
    r.last_vehicle = lv;
    return r;
  endfunction

  function automatic longint rand_coord();
    if ($urandom_range(0, 7) == 0) return longint'($signed($urandom_range(0, 32'hFFFFFF) << 8)) >>> 8;
    return longint'($urandom_range(0, 4000)) - 2000;
  endfunction

  task automatic send(input req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    classify(r);
    requests_sent++;
    burst_left--;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    burst_left = 0;
    while (expected_conditions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input longint v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v[THR_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    threshold = v & 64'hFFFF;
  endtask

  task automatic test_directed();
    send(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    send(mk(REQ_APPEND, 0, 0, 0, 0, 0, 0, 0));
    send(mk(REQ_APPEND, 160, 0, 0, 0, 0, 0, 0));
    send(mk(REQ_APPEND, 160, 160, 0, 0, 0, 0, 0));
    send(mk(REQ_APPEND, 0, 160, 0, 0, 0, 0, 0));
    send(mk(REQ_APPEND, 0, 0, 0, 0, 1, 0, 0));
    send(mk(REQ_QUERY, -80, 80, 240, 80, 0, 1, 0));
    send(mk(REQ_QUERY, -80, 400, 240, 400, 0, 1, 0));
    send(mk(REQ_QUERY, 160, 160, 400, 400, 0, 1, 0));
    send(mk(REQ_QUERY, -80, 0, 400, 0, 0, 1, 0));
    send(mk(REQ_QUERY, 800, -100, 800, 100, 0, 0, 0));
    send(mk(REQ_VEHICLE, 800, 0, 0, 0, 0, 0, 1));
    send(mk(REQ_QUERY, -1000, 1000, 1000, 1000, 0, 0, 0));
    send(mk(REQ_VEHICLE, 0, 1010, 0, 0, 0, 0, 0));
    send(mk(REQ_VEHICLE, 0, 5000, 0, 0, 0, 0, 1));
    send(mk(REQ_QUERY, -80, 80, 240, 80, 0, 0, 0));
    send(mk(REQ_VEHICLE, 100, 80, 0, 0, 0, 0, 1));
    send(mk(REQ_QUERY, -1000, 900, 1000, 900, 0, 0, 0));
    send(mk(REQ_QUERY, -1000, 900, 1000, 900, 0, 1, 0));
    send(mk(REQ_APPEND, 2000, 0, 0, 0, 0, 0, 0));
    send(mk(REQ_APPEND, 2000, 500, 0, 0, 0, 0, 0));
    send(mk(REQ_QUERY, 1900, 250, 2100, 250, 0, 1, 0));
    send(mk(REQ_QUERY, CMAX, CMAX, CMIN, CMIN, 0, 1, 0));
    send(mk(REQ_QUERY, CMIN, CMAX, CMAX, CMIN, 0, 0, 0));
    send(mk(REQ_VEHICLE, CMIN, CMAX, CMIN, CMAX, 1, 1, 1));
  endtask

  task automatic test_overflow();
    send(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < CORNER_DEPTH + 3; i++)
      send(mk(REQ_APPEND, rand_coord(), rand_coord(), 0, 0, $urandom_range(0, 3) == 0, 0, 0));
    send(mk(REQ_QUERY, rand_coord(), rand_coord(), rand_coord(), rand_coord(), 0, 1, 0));
    send(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    send(mk(REQ_QUERY, 0, 0, 100, 100, 0, 1, 0));
  endtask

  task automatic random_mix(input int count);
    int stop_at, w, n, k;
    longint cx, cy, vx, vy;
    req_t r;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      w = $urandom_range(0, 99);
      if (corner_cnt > 48 || w < 3) begin
        r = mk(REQ_CLEAR, rand_coord(), rand_coord(), rand_coord(), rand_coord(), 0, 0, 0);
        r.building_end = $urandom; r.no_vehicles = $urandom; r.last_vehicle = $urandom;
        send(r);
      end else if (w < 40) begin
        n = $urandom_range(2, 5);
        cx = longint'($urandom_range(0, 3000)) - 1500;
        cy = longint'($urandom_range(0, 3000)) - 1500;
        for (int i = 0; i < n; i++) begin
          r = mk(REQ_APPEND, cx + longint'($urandom_range(0, 600)) - 300,
                 cy + longint'($urandom_range(0, 600)) - 300, rand_coord(), rand_coord(),
                 (i == n - 1) && ($urandom_range(0, 9) != 0), $urandom, $urandom);
          send(r);
        end
      end else if (w < 80) begin
        send(mk(REQ_QUERY, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                $urandom, $urandom_range(0, 2) == 0, $urandom));
        if (expected_conditions.size() == 0 || $urandom_range(0, 1) == 0) begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 8);
            vx = link_x1 + (link_x2 - link_x1) * k / 8;
            vy = link_y1 + (link_y2 - link_y1) * k / 8 + longint'($urandom_range(0, 160)) - 80;
            send(mk(REQ_VEHICLE, vx, vy, rand_coord(), rand_coord(), $urandom, $urandom,
                    (i == n - 1) && ($urandom_range(0, 9) != 0)));
          end
        end
      end else begin
        r = mk(req_kind_t'($urandom_range(0, 3)), rand_coord(), rand_coord(), rand_coord(),
               rand_coord(), $urandom, $urandom, $urandom);
        send(r);
      end
    end
  endtask

  task automatic test_random();
    random_mix(165);
    write_threshold(0);
    random_mix(165);
    write_threshold(65535);
    random_mix(165);
    write_threshold($urandom_range(1, 65534));
    random_mix(165);
    write_threshold(32);
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      case ((cycle_cnt / 200) % 3)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 3) == 0);
        default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (expected_conditions.size() == 0) begin
        $error("unexpected result condition=%0d overflow=%0d", rsp.condition, rsp.table_overflow);
        errors++;
      end else begin
        want = expected_conditions.pop_front();
        if (rsp.condition !== want.condition) begin
          $error("condition: expected %0d, got %0d", want.condition, rsp.condition);
          errors++;
        end
        if (rsp.table_overflow !== want.table_overflow) begin
          $error("table_overflow: expected %0d, got %0d", want.table_overflow,
                 rsp.table_overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    requests_sent = 0;
    burst_left = 0;
    corner_cnt = 0;
    overflow_seen = 1'b0;
    link_x1 = 0; link_y1 = 0; link_x2 = 0; link_y2 = 0;
    blocked_by_building = 1'b0;
    blocked_by_vehicle = 1'b0;
    threshold = 32;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random();
    drain();
    $display("tb_top: %0d requests sent, %0d results checked, %0d mismatches", requests_sent,
             results_seen, errors);
    $display("tb_top: covered building edges, vehicle blocking, overflow, four thresholds");
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/los_pkg.sv
hw/rtl/los_ram.sv
hw/rtl/line_of_sight_classifier_unit.sv
hw/rtl/los_chk.sv
tb/sv/tb_top.sv
